// File: rtl/pbo_pkg.sv
package pbo_pkg;

  // Fixed-point formats of the datapath.
  localparam int unsigned PhaseBits  = 24;
  localparam int unsigned StepBits   = 23;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned Frac       = 23;
  localparam int unsigned SigBits    = 28;  // Q.23 working value with headroom
  localparam int unsigned MulBits    = 28;
  localparam int unsigned ProdBits   = 48;
  localparam int unsigned DivSteps   = 23;
  localparam int unsigned CntBits    = 5;

  // Configuration port.
  localparam int unsigned ApbAddrBits = 3;
  localparam int unsigned ApbDataBits = 32;
  localparam logic [ApbAddrBits-3:0] RegOscMode = '0;

  // Waveform codes; the last one has no waveform behind it.
  localparam logic [1:0] ModeSaw    = 2'd0;
  localparam logic [1:0] ModePulse  = 2'd1;
  localparam logic [1:0] ModeTri    = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  // Constants.
  localparam logic [PhaseBits-1:0] DutyLo = 24'd838861;
  localparam logic [PhaseBits-1:0] DutyHi = 24'd15938355;
  localparam logic [PhaseBits-1:0] Half   = 24'h800000;
  localparam logic [PhaseBits-1:0] Unity  = 24'h800000;
  localparam logic signed [MulBits-1:0] KeepCoef = 28'sd65208;
  localparam logic signed [MulBits-1:0] FeedCoef = 28'sd328;

  typedef logic [StepBits-1:0]         step_t;
  typedef logic [PhaseBits-1:0]        phase_t;
  typedef logic signed [SampleBits-1:0] sample_t;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_SQR   = 9'b000001000,
    S_ADD   = 9'b000010000,
    S_KEEP  = 9'b000100000,
    S_FEED  = 9'b001000000,
    S_INTEG = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

endpackage

// File: rtl/pbo_in_if.sv
interface pbo_in_if import pbo_pkg::*; ();
  logic   valid;
  logic   ready;
  step_t  phase_step;
  phase_t duty;
  logic   restart;
  phase_t start_phase;

  modport source (output valid, phase_step, duty, restart, start_phase, input ready);
  modport sink   (input valid, phase_step, duty, restart, start_phase, output ready);
endinterface

// File: rtl/pbo_out_if.sv
interface pbo_out_if import pbo_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

// File: rtl/polyblep_oscillator_core.sv
// Channel   Direction  Payload                                      Transfer
// in_if     sink       phase_step, duty, restart, start_phase       valid & ready
// out_if    source     sample (signed Q1.15)                        valid & ready
// APB       slave      osc_mode at byte address 0                   psel & penable & pwrite & pready
//
// Each polyBLEP edge costs one 23-step restoring division by phase_step plus a
// squaring on the shared multiplier; triangle adds two more products on that
// multiplier. The input is ready only while the sequencer is idle. Reset clears
// the phase, the integrator and the mode. A stalled output holds the finished
// sample; the next item is still taken and waits before its own output write.
module polyblep_oscillator_core import pbo_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  pbo_in_if.sink                 in_if,
  pbo_out_if.source              out_if,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAddrBits-1:0] paddr,
  input  logic [ApbDataBits-1:0] pwdata,
  output logic [ApbDataBits-1:0] prdata,
  output logic                   pready
);

  state_e state_q, state_d;

  logic [1:0]  mode_q;
  phase_t      phase_acc_q;
  logic signed [PhaseBits-1:0] integ_q;

  step_t       step_q;
  phase_t      t_q;
  phase_t      pw_q;
  logic        job_q;
  logic        neg_q;
  logic [StepBits-1:0] rem_q;
  logic [StepBits-1:0] quo_q;
  logic [CntBits-1:0]  cnt_q;
  logic signed [SigBits-1:0]  y_q;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [ProdBits-1:0] acc_q;
  logic        out_valid_q;
  sample_t     sample_q;

  logic in_fire;
  logic cfg_wr;
  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.sample = sample_q;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ApbAddrBits-1:2] == RegOscMode);
  assign prdata = (paddr[ApbAddrBits-1:2] == RegOscMode) ? {30'd0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeSaw;
    end else if (cfg_wr) begin
      mode_q <= pwdata[1:0];
    end
  end

  // Input decode: duty clamp and start phase.
  phase_t duty_c;
  phase_t t_start;
  always_comb begin
    duty_c = in_if.duty;
    if (in_if.duty < DutyLo) duty_c = DutyLo;
    if (in_if.duty > DutyHi) duty_c = DutyHi;
    t_start = in_if.restart ? in_if.start_phase : phase_acc_q;
  end

  // Base waveform value before edge corrections.
  logic signed [SigBits-1:0] y_base;
  always_comb begin
    case (mode_q)
      ModeSaw:   y_base = $signed({4'd0, t_start}) - $signed({4'd0, Unity});
      ModePulse: y_base = (t_start < duty_c) ? $signed({4'd0, Unity})
                                             : -$signed({4'd0, Unity});
      ModeTri:   y_base = (t_start < Half) ? $signed({4'd0, Unity})
                                           : -$signed({4'd0, Unity});
      default:   y_base = '0;
    endcase
  end

  // Edge classification for the current correction job.
  phase_t tt;
  phase_t split;
  logic [PhaseBits:0] tt_sum;
  logic near_lo, near_hi, job_active, more_jobs;
  phase_t num_hi;
  always_comb begin
    split   = (mode_q == ModePulse) ? pw_q : Half;
    tt      = job_q ? (t_q - split) : t_q;
    tt_sum  = {1'b0, tt} + {2'b0, step_q};
    near_lo = (tt < {1'b0, step_q});
    near_hi = tt_sum[PhaseBits] && (tt_sum[PhaseBits-1:0] != '0);
    num_hi  = '0 - tt;
    job_active = (step_q != '0) && (near_lo || near_hi);
    more_jobs  = !job_q && (mode_q != ModeSaw);
  end

  // Divider step: one quotient bit per cycle.
  logic [StepBits:0]   rem2;
  logic                q_bit;
  logic [StepBits:0]   rem_sub;
  always_comb begin
    rem2    = {rem_q, 1'b0};
    q_bit   = (rem2 >= {1'b0, step_q});
    rem_sub = rem2 - {1'b0, step_q};
  end

  // Shared multiplier operand select.
  logic [PhaseBits-1:0] r_val;
  logic signed [MulBits-1:0] mul_a, mul_b;
  logic signed [2*MulBits-1:0] mul_p;
  always_comb begin
    r_val = Unity - {1'b0, quo_q};
    case (state_q)
      S_SQR: begin
        mul_a = $signed({4'd0, r_val});
        mul_b = $signed({4'd0, r_val});
      end
      S_KEEP: begin
        mul_a = KeepCoef;
        mul_b = MulBits'(integ_q);
      end
      S_FEED: begin
        mul_a = FeedCoef;
        mul_b = y_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Correction magnitude and integrator update.
  logic [PhaseBits-1:0] mag;
  logic signed [ProdBits-1:0] integ_sum;
  logic signed [ProdBits-17:0] integ_shr;
  logic signed [PhaseBits-1:0] integ_new;
  logic sub_mag;
  always_comb begin
    mag       = prod_q[2*Frac:Frac];
    sub_mag   = neg_q ^ ((mode_q == ModeSaw) || job_q);
    integ_sum = acc_q + prod_q;
    integ_shr = integ_sum[ProdBits-1:16];
    if (integ_shr < -$signed({{(ProdBits-16-PhaseBits){1'b0}}, Unity})) begin
      integ_new = $signed({1'b1, {(PhaseBits-1){1'b0}}});
    end else if (integ_shr > $signed({{(ProdBits-16-PhaseBits){1'b0}}, Unity}) - 1) begin
      integ_new = $signed({1'b0, {(PhaseBits-1){1'b1}}});
    end else begin
      integ_new = integ_shr[PhaseBits-1:0];
    end
  end

  // Output rounding and saturation.
  logic signed [SigBits-1:0] y_rnd;
  logic signed [SigBits-9:0] y_shr;
  sample_t sample_new;
  always_comb begin
    y_rnd = y_q + SigBits'(128);
    y_shr = y_rnd[SigBits-1:8];
    if (y_shr > $signed(20'sd32767)) begin
      sample_new = 16'sh7fff;
    end else if (y_shr < $signed(-20'sd32768)) begin
      sample_new = 16'sh8000;
    end else begin
      sample_new = y_shr[SampleBits-1:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_if.ready;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = (mode_q == ModeUnused) ? S_DONE : S_PREP;
      S_PREP: begin
        if (job_active) begin
          state_d = S_DIV;
        end else if (!more_jobs) begin
          state_d = (mode_q == ModeTri) ? S_KEEP : S_DONE;
        end
      end
      S_DIV:   if (cnt_q == CntBits'(DivSteps - 1)) state_d = S_SQR;
      S_SQR:   state_d = S_ADD;
      S_ADD: begin
        if (more_jobs) begin
          state_d = S_PREP;
        end else begin
          state_d = (mode_q == ModeTri) ? S_KEEP : S_DONE;
        end
      end
      S_KEEP:  state_d = S_FEED;
      S_FEED:  state_d = S_INTEG;
      S_INTEG: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_acc_q <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
      job_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        phase_acc_q <= t_start + {1'b0, in_if.phase_step};
        job_q       <= 1'b0;
      end
      if (state_q == S_PREP && !job_active && more_jobs) job_q <= 1'b1;
      if (state_q == S_ADD && more_jobs) job_q <= 1'b1;
      if (state_q == S_PREP) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_INTEG) integ_q <= integ_new;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      step_q <= in_if.phase_step;
      t_q    <= t_start;
      pw_q   <= duty_c;
      y_q    <= y_base;
    end
    if (state_q == S_PREP) begin
      neg_q <= near_lo;
      rem_q <= near_lo ? tt[StepBits-1:0] : num_hi[StepBits-1:0];
      quo_q <= '0;
    end
    if (state_q == S_DIV) begin
      rem_q <= q_bit ? rem_sub[StepBits-1:0] : rem2[StepBits-1:0];
      quo_q <= {quo_q[StepBits-2:0], q_bit};
    end
    if (state_q == S_SQR || state_q == S_KEEP || state_q == S_FEED) begin
      prod_q <= mul_p[ProdBits-1:0];
    end
    if (state_q == S_ADD) begin
      y_q <= sub_mag ? y_q - $signed({4'd0, mag}) : y_q + $signed({4'd0, mag});
    end
    if (state_q == S_FEED) acc_q <= prod_q + ProdBits'(32768);
    if (state_q == S_INTEG) y_q <= SigBits'(integ_new);
    if (state_q == S_DONE && out_free) sample_q <= sample_new;
  end

  // Checks on the sequencer and datapath.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ({1'b0, rem_q} < {1'b0, step_q}))
    else $error("divider remainder reached the divisor");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("output raised outside the done state");

  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ModeTri) |=> $stable(integ_q))
    else $error("integrator changed outside triangle mode");

endmodule

// File: tb/sv/polyblep_oscillator_core_tb.sv
`timescale 1ns / 1ps

module polyblep_oscillator_core_tb import pbo_pkg::*; ();

  localparam logic [ApbAddrBits-1:0] ModeAddr     = {RegOscMode, 2'b00};
  localparam logic [ApbAddrBits-1:0] UnmappedAddr = 3'd4;

  localparam int DrainCycles = 64;
  localparam int StallLimit  = 4000;
  localparam int RandomTicks = 700;

  localparam step_t  StepMax  = '1;
  localparam phase_t PhaseMax = '1;

  // Fixed-point constants of the sample prediction.
  localparam longint PhaseOne   = longint'(1) << PhaseBits;
  localparam longint PhaseMask  = PhaseOne - 1;
  localparam longint HalfPhase  = PhaseOne / 2;
  localparam longint UnitQ      = longint'(1) << Frac;
  localparam longint IntegRound = longint'(1) << 15;
  localparam int     OutShift   = Frac - SampleBits + 1;
  localparam longint OutRound   = longint'(1) << (OutShift - 1);
  localparam longint SampleMax  = (longint'(1) << (SampleBits - 1)) - 1;
  localparam longint SampleMin  = -SampleMax - 1;

  // Tracks the oscillator state and the samples still owed by the block.
  class osc_scoreboard;
    logic [1:0] wave_mode;
    longint     phase;
    longint     integ;
    sample_t    expected_samples[$];
    int         failures;

    function new();
      wave_mode = ModeSaw;
      phase     = 0;
      integ     = 0;
      failures  = 0;
    endfunction

    // PolyBLEP correction around a wrap of phase t for step d.
    function longint edge_fix(longint t, longint d);
      longint r;
      if (d == 0) return 0;
      if (t < d) begin
        r = UnitQ - ((t << Frac) / d);
        return -((r * r) >>> Frac);
      end
      if (PhaseOne - t < d) begin
        r = UnitQ - (((PhaseOne - t) << Frac) / d);
        return (r * r) >>> Frac;
      end
      return 0;
    endfunction

    // Advances the oscillator by one accepted tick and queues its sample.
    function void note_tick(step_t step, phase_t duty, logic restart, phase_t start);
      longint d;
      longint pw;
      longint t;
      longint y;
      longint sq;
      d  = step;
      pw = duty;
      if (pw < DutyLo) pw = DutyLo;
      if (pw > DutyHi) pw = DutyHi;
      if (restart) phase = start;
      t = phase;

      case (wave_mode)
        ModeSaw: begin
          y = t - UnitQ - edge_fix(t, d);
        end
        ModePulse: begin
          y = ((t < pw) ? UnitQ : -UnitQ) + edge_fix(t, d)
              - edge_fix((t - pw) & PhaseMask, d);
        end
        ModeTri: begin
          sq = ((t < HalfPhase) ? UnitQ : -UnitQ) + edge_fix(t, d)
               - edge_fix((t - HalfPhase) & PhaseMask, d);
          integ = (longint'(KeepCoef) * integ + longint'(FeedCoef) * sq + IntegRound) >>> 16;
          if (integ < -UnitQ) integ = -UnitQ;
          if (integ > UnitQ - 1) integ = UnitQ - 1;
          y = integ;
        end
        default: begin
          y = 0;
        end
      endcase

      phase = (t + d) & PhaseMask;

      // Round half up to the output format and saturate.
      y = (y + OutRound) >>> OutShift;
      if (y < SampleMin) y = SampleMin;
      if (y > SampleMax) y = SampleMax;
      expected_samples.push_back(sample_t'(y));
    endfunction

    // Compares an output transfer with the oldest owed sample.
    function void check_sample(sample_t got);
      sample_t want;
      if (expected_samples.size() == 0) begin
        failures++;
        if (failures <= 10) $display("sample %0d arrived with no tick outstanding", got);
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) $display("sample mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ApbAddrBits-1:0] paddr;
  logic [ApbDataBits-1:0] pwdata;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  int            send_idle_pct;
  int            recv_idle_pct;
  int            stall_cycles = 0;
  osc_scoreboard sb;

  pbo_in_if  in_if ();
  pbo_out_if out_if ();

  polyblep_oscillator_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // The sample receiver stalls at random.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Observe transfers on both channels and count cycles without progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_sample(out_if.sample);
      if (in_if.valid && in_if.ready) begin
        sb.note_tick(in_if.phase_step, in_if.duty, in_if.restart, in_if.start_phase);
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) || psel) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Watchdog on a run that stops making progress.
  initial begin
    do @(posedge clk_i); while (stall_cycles < StallLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one tick after a random gap and waits for its transfer.
  task automatic send_tick(input step_t step, input phase_t duty, input logic restart,
                           input phase_t start);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.phase_step  <= step;
    in_if.duty        <= duty;
    in_if.restart     <= restart;
    in_if.start_phase <= start;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Writes a register once the block has delivered every owed sample.
  task automatic write_osc_reg(input logic [ApbAddrBits-1:0] addr,
                               input logic [ApbDataBits-1:0] data);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[ApbAddrBits-1:2] == RegOscMode) sb.wave_mode = data[1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Field extremes, every waveform and the corner cases of each.
  task automatic run_directed();
    // Saw from the reset mode.
    send_tick('0, '0, 1'b0, '0);
    send_tick(StepMax, '0, 1'b1, '0);
    send_tick(StepMax, '0, 1'b1, PhaseMax);
    send_tick(23'h400000, 24'h800000, 1'b1, 24'h800000);
    send_tick(23'd1, '0, 1'b1, '0);

    // Pulse, with both duty clamps and an edge pushing past full scale.
    write_osc_reg(ModeAddr, {30'h3FFFFFFF, ModePulse});
    send_tick(23'h100000, '0, 1'b1, '0);
    send_tick(StepMax, PhaseMax, 1'b1, 24'hF00000);
    send_tick(23'h200000, DutyLo, 1'b1, DutyLo);
    send_tick('0, 24'h800000, 1'b1, 24'h7FFFFF);
    send_tick(StepMax, 24'h800000, 1'b0, '0);

    // Triangle; a write to an unmapped address must leave the mode alone.
    write_osc_reg(ModeAddr, {30'd0, ModeTri});
    repeat (4) send_tick(23'h300000, '0, 1'b0, '0);
    send_tick(StepMax, '0, 1'b1, 24'h7FFFFF);
    send_tick('0, '0, 1'b1, '0);
    write_osc_reg(UnmappedAddr, {30'd0, ModeSaw});
    send_tick(23'h123456, 24'hABCDEF, 1'b0, '0);

    // Unused mode gives silence while the phase keeps moving.
    write_osc_reg(ModeAddr, {30'd0, ModeUnused});
    send_tick(StepMax, '0, 1'b0, '0);
    send_tick(23'h7, PhaseMax, 1'b1, 24'h00FFFF);

    // The integrator must hold through saw and resume in triangle.
    write_osc_reg(ModeAddr, {30'd0, ModeSaw});
    send_tick(23'h010000, '0, 1'b0, '0);
    write_osc_reg(ModeAddr, {30'd0, ModeTri});
    send_tick(23'h010000, '0, 1'b0, '0);
  endtask

  // Notes held for a while with random pitch, width and occasional restarts.
  task automatic run_random();
    int                   done;
    int                   seg_len;
    int                   run_len;
    int                   pick;
    int                   k;
    logic [ApbDataBits-1:0] mode_word;
    step_t                note;
    step_t                step;
    phase_t               width;
    phase_t               duty;
    logic                 restart;
    done = 0;
    while (done < RandomTicks) begin
      if (done < RandomTicks / 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 73;
      end else if (done < 2 * RandomTicks / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // New waveform for this segment, upper register bits random.
      pick = $urandom_range(9);
      mode_word = $urandom();
      mode_word[1:0] = (pick < 3) ? ModeSaw : (pick < 6) ? ModePulse :
                       (pick < 9) ? ModeTri : ModeUnused;
      write_osc_reg(ModeAddr, mode_word);

      seg_len = $urandom_range(30, 80);
      while (seg_len > 0) begin
        run_len = $urandom_range(4, 40);
        pick = $urandom_range(19);
        if (pick == 0) note = '0;
        else if (pick == 1) note = StepMax;
        else if (pick < 8) note = step_t'($urandom());
        else if (pick < 14) note = step_t'($urandom_range(1, 1 << 18));
        else note = step_t'($urandom_range(1 << 18, 1 << 22));
        width = phase_t'($urandom());
        k = 0;
        while (k < run_len && seg_len > 0) begin
          step    = ($urandom_range(9) == 0) ? step_t'($urandom()) : note;
          duty    = ($urandom_range(4) == 0) ? phase_t'($urandom()) : width;
          restart = (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(19) == 0);
          send_tick(step, duty, restart, phase_t'($urandom()));
          k++;
          seg_len--;
          done++;
        end
      end
    end
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.phase_step  = '0;
    in_if.duty        = '0;
    in_if.restart     = 1'b0;
    in_if.start_phase = '0;
    out_if.ready      = 1'b0;
    send_idle_pct     = 17;
    recv_idle_pct     = 73;
    sb                = new();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random();

    // Let the last samples drain before the verdict.
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
